// ===== rtl/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the window memory write receiver: command
// codes, the operation carried from the front decoder to the back executor,
// and the depth of the queue between them.
// ----------------------------------------------------------------------------
package lcdw_pkg;

	// Command bytes understood by the receiver
	localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
	localparam logic [7:0] CMD_PAGE_ADDR    = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

	// Operation queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Operation kinds handed to the back end
	typedef enum logic [1:0] {
		OP_COL_ADDR = 2'd0,
		OP_ROW_ADDR = 2'd1,
		OP_HOME     = 2'd2,
		OP_PIXEL    = 2'd3
	} lcdw_op_kind_t;

	// Address byte slot: start high, start low, end high, end low
	localparam logic [1:0] SLOT_START_HI = 2'd0;
	localparam logic [1:0] SLOT_START_LO = 2'd1;
	localparam logic [1:0] SLOT_END_HI   = 2'd2;
	localparam logic [1:0] SLOT_END_LO   = 2'd3;

	typedef struct packed {
		lcdw_op_kind_t kind;
		logic [1:0]    slot;   // address byte slot, address operations only
		logic [15:0]   data;   // address byte in [7:0], or pixel colour
	} lcdw_op_t;

endpackage

// ===== rtl/lcd_window_memory_write_receiver.sv =====
// ----------------------------------------------------------------------------
// lcd_window_memory_write_receiver
// Panel-side receiver for column address, page address and memory write
// byte streams; emits each in-panel written pixel with its row and column.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  byte    | byte_valid / byte_ready    | is_data, bus_byte
//  pixel   | pixel_valid / pixel_ready  | pixel_column, pixel_row, pixel_color
//
//  One byte is taken every cycle while byte_ready is high; a pixel beat is
//  written into the queue at the edge that takes its low byte, and the
//  executor then moves it into the output register. The executor retires one
//  operation per cycle unless a pixel waits on a held output register. The
//  four-entry operation queue absorbs output stalls; byte_ready drops only
//  when it is full. Reset (arst_n low) clears the decoder, queue, window to
//  the full panel and cursor to the origin.
// ----------------------------------------------------------------------------
module lcd_window_memory_write_receiver
	import lcdw_pkg::*;
#(
	parameter int PANEL_COLUMNS = 240,
	parameter int PANEL_ROWS    = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic        is_data,
	input  logic [7:0]  bus_byte,
	output logic        pixel_valid,
	input  logic        pixel_ready,
	output logic [7:0]  pixel_column,
	output logic [7:0]  pixel_row,
	output logic [15:0] pixel_color
);

	logic     push;
	lcdw_op_t push_op;
	logic     queue_full;
	logic     head_valid;
	lcdw_op_t head_op;
	logic     pop;

	lcdw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.is_data    (is_data),
		.bus_byte   (bus_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_op    (push_op)
	);

	lcdw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop)
	);

	lcdw_back #(
		.PANEL_COLUMNS (PANEL_COLUMNS),
		.PANEL_ROWS    (PANEL_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_op      (head_op),
		.pop          (pop),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.pixel_color  (pixel_color)
	);

endmodule

// ===== rtl/lcdw_front.sv =====
// ----------------------------------------------------------------------------
// lcdw_front
// Byte decoder: tracks the current command, the address parameter position
// and pixel byte pairing, and turns each useful beat into one operation.
// ----------------------------------------------------------------------------
module lcdw_front
	import lcdw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic        is_data,
	input  logic [7:0]  bus_byte,
	input  logic        queue_full,
	output logic        push,
	output lcdw_op_t    push_op
);

	logic [7:0] current_command_q;
	logic [1:0] param_index_q;
	logic [7:0] pending_high_q;
	logic       byte_phase_q;
	logic       accept;
	logic       op_valid;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;
	assign push       = accept && op_valid;

	// Classify the incoming beat
	always_comb begin
		op_valid     = 1'b0;
		push_op.kind = OP_HOME;
		push_op.slot = param_index_q;
		push_op.data = {8'h00, bus_byte};
		if (!is_data) begin
			op_valid = (bus_byte == CMD_MEMORY_WRITE);
		end else begin
			case (current_command_q)
				CMD_COLUMN_ADDR: begin
					op_valid     = 1'b1;
					push_op.kind = OP_COL_ADDR;
				end
				CMD_PAGE_ADDR: begin
					op_valid     = 1'b1;
					push_op.kind = OP_ROW_ADDR;
				end
				CMD_MEMORY_WRITE: begin
					op_valid     = byte_phase_q;
					push_op.kind = OP_PIXEL;
					push_op.data = {pending_high_q, bus_byte};
				end
				default: begin
					op_valid = 1'b0;
				end
			endcase
		end
	end

	// Advance decoder state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_command_q <= 8'h00;
			param_index_q     <= 2'd0;
			pending_high_q    <= 8'h00;
			byte_phase_q      <= 1'b0;
		end else if (accept) begin
			if (!is_data) begin
				current_command_q <= bus_byte;
				param_index_q     <= 2'd0;
				byte_phase_q      <= 1'b0;
			end else if (current_command_q == CMD_COLUMN_ADDR ||
			             current_command_q == CMD_PAGE_ADDR) begin
				param_index_q <= param_index_q + 2'd1;
			end else if (current_command_q == CMD_MEMORY_WRITE) begin
				if (!byte_phase_q) begin
					pending_high_q <= bus_byte;
				end
				byte_phase_q <= !byte_phase_q;
			end
		end
	end

	// A half pixel can only be pending under a memory write
	a_phase_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		byte_phase_q |-> current_command_q == CMD_MEMORY_WRITE)
		else $error("pixel byte pending outside memory write");

endmodule

// ===== rtl/lcdw_queue.sv =====
// ----------------------------------------------------------------------------
// lcdw_queue
// Short first-in first-out buffer of operations between decoder and
// executor, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module lcdw_queue
	import lcdw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lcdw_op_t push_op,
	output logic     full,
	output logic     head_valid,
	output lcdw_op_t head_op,
	input  logic     pop
);

	lcdw_op_t                 entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entries_q[rd_ptr_q];

	// Store pushed operations
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop) && count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("operation queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("operation queue underflow");

endmodule

// ===== rtl/lcdw_back.sv =====
// ----------------------------------------------------------------------------
// lcdw_back
// Executor: holds the window and cursor, applies address bytes, homes the
// cursor and places pixels, with a registered pixel output.
// ----------------------------------------------------------------------------
module lcdw_back
	import lcdw_pkg::*;
#(
	parameter int PANEL_COLUMNS = 240,
	parameter int PANEL_ROWS    = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  lcdw_op_t    head_op,
	output logic        pop,
	output logic        pixel_valid,
	input  logic        pixel_ready,
	output logic [7:0]  pixel_column,
	output logic [7:0]  pixel_row,
	output logic [15:0] pixel_color
);

	logic [15:0] win_col_start_q;
	logic [15:0] win_col_end_q;
	logic [15:0] win_row_start_q;
	logic [15:0] win_row_end_q;
	logic [15:0] cursor_col_q;
	logic [15:0] cursor_row_q;
	logic        out_valid_q;
	logic [7:0]  out_column_q;
	logic [7:0]  out_row_q;
	logic [15:0] out_color_q;
	logic        in_panel;
	logic        emits;
	logic        out_free;

	assign in_panel = (cursor_col_q < 16'(PANEL_COLUMNS)) && (cursor_row_q < 16'(PANEL_ROWS));
	assign emits    = (head_op.kind == OP_PIXEL) && in_panel;
	assign out_free = !out_valid_q || pixel_ready;
	assign pop      = head_valid && (!emits || out_free);

	// Apply operations to window and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_col_start_q <= 16'h0000;
			win_col_end_q   <= 16'(PANEL_COLUMNS - 1);
			win_row_start_q <= 16'h0000;
			win_row_end_q   <= 16'(PANEL_ROWS - 1);
			cursor_col_q    <= 16'h0000;
			cursor_row_q    <= 16'h0000;
		end else if (pop) begin
			case (head_op.kind)
				OP_COL_ADDR: begin
					case (head_op.slot)
						SLOT_START_HI: win_col_start_q[15:8] <= head_op.data[7:0];
						SLOT_START_LO: win_col_start_q[7:0]  <= head_op.data[7:0];
						SLOT_END_HI:   win_col_end_q[15:8]   <= head_op.data[7:0];
						default:       win_col_end_q[7:0]    <= head_op.data[7:0];
					endcase
				end
				OP_ROW_ADDR: begin
					case (head_op.slot)
						SLOT_START_HI: win_row_start_q[15:8] <= head_op.data[7:0];
						SLOT_START_LO: win_row_start_q[7:0]  <= head_op.data[7:0];
						SLOT_END_HI:   win_row_end_q[15:8]   <= head_op.data[7:0];
						default:       win_row_end_q[7:0]    <= head_op.data[7:0];
					endcase
				end
				OP_HOME: begin
					cursor_col_q <= win_col_start_q;
					cursor_row_q <= win_row_start_q;
				end
				default: begin
					// Advance row-major, wrap to the window start
					if (cursor_col_q >= win_col_end_q) begin
						cursor_col_q <= win_col_start_q;
						if (cursor_row_q >= win_row_end_q) begin
							cursor_row_q <= win_row_start_q;
						end else begin
							cursor_row_q <= cursor_row_q + 16'd1;
						end
					end else begin
						cursor_col_q <= cursor_col_q + 16'd1;
					end
				end
			endcase
		end
	end

	// Hold the pixel beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (pixel_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			out_column_q <= cursor_col_q[7:0];
			out_row_q    <= cursor_row_q[7:0];
			out_color_q  <= head_op.data;
		end
	end

	assign pixel_valid  = out_valid_q;
	assign pixel_column = out_column_q;
	assign pixel_row    = out_row_q;
	assign pixel_color  = out_color_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pixel_ready) |-> !(pop && emits))
		else $error("pending pixel overwritten");

	a_emit_in_panel: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emits) |=> out_valid_q && 16'(out_column_q) < 16'(PANEL_COLUMNS))
		else $error("pixel emitted outside the panel");

endmodule
